[hdl/terminated_frame_receiver_macros.svh]
// assertion helpers for the frame receiver checker
`ifndef TERMINATED_FRAME_RECEIVER_MACROS_SVH
`define TERMINATED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, off while in reset
`define TFR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define TFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tfr_pkg.sv]
package tfr_pkg;

    localparam int DEF_FRAME_DEPTH  = 32;
    localparam int DEF_MAX_TERM_LEN = 4;

    localparam int PING_LEN = 4;
    localparam logic [7:0] PING_WORD [PING_LEN] = '{8'h50, 8'h49, 8'h4E, 8'h47};

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_PING = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_PONG       = 3'd2,
        ST_BAD_PING   = 3'd3,
        ST_FRAME_TOUT = 3'd4,
        ST_PING_TOUT  = 3'd5,
        ST_OVERFLOW   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REG_TERM_LEN   = 2'd0,
        REG_TERM_BYTES = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_ECHO       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        SRC_STATUS = 2'd0,
        SRC_FRAME  = 2'd1,
        SRC_PING   = 2'd2,
        SRC_TERM   = 2'd3
    } t_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_BYTE_CHK,
        S_OVF,
        S_TOUT,
        S_ACC_START,
        S_EMPTY,
        S_FRM_RD,
        S_FRM_OUT,
        S_AFTER,
        S_VERDICT,
        S_TERM,
        S_DONE,
        S_PING,
        S_PTERM
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    byte_upd;
        logic    tick_dec;
        logic    expire;
        logic    ping_start;
        logic    acc_done;
        logic    idx_clear;
        logic    idx_inc;
        logic    emit;
        t_src    src;
        t_status status;
        logic    last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic term_hit;
        logic armed;
        logic left_gt1;
        logic len_zero;
        logic cnt_zero;
        logic flen_zero;
        logic ping_pending;
        logic echo;
        logic frm_end;
        logic term_end;
        logic ping_end;
        logic pong;
        logic can_load;
    } t_stat;

endpackage

[hdl/tfr_ctrl.sv]
module tfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tfr_pkg::t_stat i_stat,
    output tfr_pkg::t_cmd  o_cmd
);
    import tfr_pkg::*;

    t_state r_state, n_state;
    logic   tail_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // nothing follows the frame bytes: no ping verdict and no echoed terminator
    assign tail_none = !i_stat.ping_pending && !(i_stat.echo && !i_stat.len_zero);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.src    = SRC_STATUS;
        o_cmd.status = ST_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_BYTE: begin
                        o_cmd.byte_upd = 1'b1;
                        n_state        = i_stat.full ? S_OVF : S_BYTE_CHK;
                    end
                    OP_TICK: begin
                        if (!i_stat.armed) begin
                            n_state = S_IDLE;
                        end else if (i_stat.left_gt1) begin
                            o_cmd.tick_dec = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.expire = 1'b1;
                            if (i_stat.len_zero && !i_stat.cnt_zero) begin
                                n_state = S_ACC_START;
                            end else begin
                                n_state = S_TOUT;
                            end
                        end
                    end
                    OP_PING: begin
                        o_cmd.ping_start = 1'b1;
                        o_cmd.idx_clear  = 1'b1;
                        n_state          = S_PING;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_BYTE_CHK: begin
                n_state = i_stat.term_hit ? S_ACC_START : S_IDLE;
            end
            S_OVF: begin
                if (i_stat.can_load) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_OVERFLOW;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_TOUT: begin
                if (i_stat.can_load) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = i_stat.ping_pending ? ST_PING_TOUT : ST_FRAME_TOUT;
                    o_cmd.last     = 1'b1;
                    o_cmd.acc_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ACC_START: begin
                o_cmd.idx_clear = 1'b1;
                n_state         = i_stat.flen_zero ? S_EMPTY : S_FRM_RD;
            end
            S_EMPTY: begin
                if (i_stat.can_load) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_EMPTY;
                    o_cmd.last   = tail_none;
                    n_state      = S_AFTER;
                end
            end
            S_FRM_RD: begin
                n_state = S_FRM_OUT;
            end
            S_FRM_OUT: begin
                if (i_stat.can_load) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = SRC_FRAME;
                    o_cmd.last    = i_stat.frm_end && tail_none;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = i_stat.frm_end ? S_AFTER : S_FRM_RD;
                end
            end
            S_AFTER: begin
                if (i_stat.ping_pending) begin
                    n_state = S_VERDICT;
                end else if (i_stat.echo && !i_stat.len_zero) begin
                    o_cmd.idx_clear = 1'b1;
                    n_state         = S_TERM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_VERDICT: begin
                if (i_stat.can_load) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = i_stat.pong ? ST_PONG : ST_BAD_PING;
                    o_cmd.last   = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_TERM: begin
                if (i_stat.can_load) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = SRC_TERM;
                    o_cmd.last    = i_stat.term_end;
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.term_end) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_cmd.acc_done = 1'b1;
                n_state        = S_IDLE;
            end
            S_PING: begin
                if (i_stat.can_load) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = SRC_PING;
                    o_cmd.last    = i_stat.ping_end && i_stat.len_zero;
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.ping_end) begin
                        if (i_stat.len_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_clear = 1'b1;
                            n_state         = S_PTERM;
                        end
                    end
                end
            end
            S_PTERM: begin
                if (i_stat.can_load) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = SRC_TERM;
                    o_cmd.last    = i_stat.term_end;
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.term_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[hdl/tfr_dpath.sv]
module tfr_dpath #(
    parameter int FRAME_DEPTH  = tfr_pkg::DEF_FRAME_DEPTH,
    parameter int MAX_TERM_LEN = tfr_pkg::DEF_MAX_TERM_LEN
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tfr_pkg::t_cmd  i_cmd,
    output tfr_pkg::t_stat o_stat,
    input  logic [1:0]     i_operation,
    input  logic [7:0]     i_rx_byte,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_data_byte,
    output logic           o_to_host,
    output logic           o_to_line,
    output logic [2:0]     o_status,
    output logic           o_last
);
    import tfr_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);

    // configuration
    logic [2:0]  r_term_len;
    logic [31:0] r_term_bytes;
    logic [15:0] r_timeout;
    logic        r_echo_en;

    // captured input word
    t_op        r_op;
    logic [7:0] r_byte;

    // frame store and receive state
    logic [7:0]        r_mem [FRAME_DEPTH];
    logic [7:0]        r_rd_data;
    logic [CNT_W-1:0]  r_count;
    logic [7:0]        r_tail [MAX_TERM_LEN];
    logic              r_ping_pending;
    logic              r_armed;
    logic [15:0]       r_timer_left;
    logic [ADDR_W-1:0] r_idx;
    logic              r_pong_ok;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_host;
    logic       r_out_line;
    t_status    r_out_status;
    logic       r_out_last;

    logic [2:0]       eff_len;
    logic [CNT_W-1:0] flen;
    logic             term_ok;
    logic             full;
    logic             echo;
    logic             can_load;
    logic             cfg_wr;
    t_reg_idx         reg_sel;

    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_len   <= 3'd1;
            r_term_bytes <= 32'd10;
            r_timeout    <= 16'd1000;
            r_echo_en    <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_TERM_LEN:   r_term_len   <= pwdata[2:0];
                REG_TERM_BYTES: r_term_bytes <= pwdata;
                REG_TIMEOUT:    r_timeout    <= pwdata[15:0];
                REG_ECHO:       r_echo_en    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TERM_LEN:   prdata = {29'd0, r_term_len};
            REG_TERM_BYTES: prdata = r_term_bytes;
            REG_TIMEOUT:    prdata = {16'd0, r_timeout};
            REG_ECHO:       prdata = {31'd0, r_echo_en};
            default:        prdata = '0;
        endcase
    end

    assign eff_len  = (r_term_len > 3'(MAX_TERM_LEN)) ? 3'(MAX_TERM_LEN) : r_term_len;
    assign flen     = r_count - CNT_W'(eff_len);
    assign full     = (r_count >= CNT_W'(FRAME_DEPTH));
    assign echo     = !r_ping_pending && r_echo_en;
    assign can_load = !r_out_valid || !i_out_stall;

    // tail age k pairs with terminator byte j when k + j + 1 equals the length
    always_comb begin
        term_ok = 1'b1;
        for (int k = 0; k < MAX_TERM_LEN; k++) begin
            for (int j = 0; j < MAX_TERM_LEN; j++) begin
                if ((3'(k + j + 1) == eff_len) && (r_tail[k] != r_term_bytes[8*j +: 8])) begin
                    term_ok = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.full         = full;
        o_stat.term_hit     = (eff_len != 3'd0) && (r_count >= CNT_W'(eff_len)) && term_ok;
        o_stat.armed        = r_armed;
        o_stat.left_gt1     = (r_timer_left > 16'd1);
        o_stat.len_zero     = (eff_len == 3'd0);
        o_stat.cnt_zero     = (r_count == '0);
        o_stat.flen_zero    = (flen == '0);
        o_stat.ping_pending = r_ping_pending;
        o_stat.echo         = echo;
        o_stat.frm_end      = ((CNT_W'(r_idx) + CNT_W'(1)) == flen);
        o_stat.term_end     = ((3'(r_idx[1:0]) + 3'd1) == eff_len);
        o_stat.ping_end     = (r_idx[1:0] == 2'(PING_LEN - 1));
        o_stat.pong         = r_pong_ok && (flen == CNT_W'(PING_LEN));
        o_stat.can_load     = can_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_ping_pending <= 1'b0;
            r_armed        <= 1'b0;
            r_timer_left   <= '0;
            r_idx          <= '0;
            r_pong_ok      <= 1'b1;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < MAX_TERM_LEN; k++) begin
                r_tail[k] <= '0;
            end
        end else begin
            if (i_cmd.byte_upd) begin
                r_armed      <= 1'b1;
                r_timer_left <= r_timeout;
                if (full) begin
                    r_count <= '0;
                    for (int k = 0; k < MAX_TERM_LEN; k++) begin
                        r_tail[k] <= '0;
                    end
                end else begin
                    r_count   <= r_count + CNT_W'(1);
                    r_tail[0] <= r_byte;
                    for (int k = 1; k < MAX_TERM_LEN; k++) begin
                        r_tail[k] <= r_tail[k-1];
                    end
                end
            end
            if (i_cmd.tick_dec) begin
                r_timer_left <= r_timer_left - 16'd1;
            end
            if (i_cmd.expire) begin
                r_timer_left <= '0;
                r_armed      <= 1'b0;
            end
            if (i_cmd.ping_start) begin
                r_ping_pending <= 1'b1;
                r_armed        <= 1'b1;
                r_timer_left   <= r_timeout;
            end
            if (i_cmd.acc_done) begin
                r_count        <= '0;
                r_armed        <= 1'b0;
                r_ping_pending <= 1'b0;
                for (int k = 0; k < MAX_TERM_LEN; k++) begin
                    r_tail[k] <= '0;
                end
            end

            if (i_cmd.idx_clear) begin
                r_idx     <= '0;
                r_pong_ok <= 1'b1;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            // collect the ping reply check while the first bytes stream out
            if (i_cmd.emit && (i_cmd.src == SRC_FRAME) && (CNT_W'(r_idx) < CNT_W'(PING_LEN))
                    && (r_rd_data != PING_WORD[r_idx[1:0]])) begin
                r_pong_ok <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: store, read port, captured input and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_upd && !full) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_byte;
        end
        r_rd_data <= r_mem[r_idx];
        if (i_cmd.load_in) begin
            r_op   <= t_op'(i_operation);
            r_byte <= i_rx_byte;
        end
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.last;
            case (i_cmd.src)
                SRC_STATUS: begin
                    r_out_data   <= '0;
                    r_out_host   <= 1'b0;
                    r_out_line   <= 1'b0;
                    r_out_status <= i_cmd.status;
                end
                SRC_FRAME: begin
                    r_out_data   <= r_rd_data;
                    r_out_host   <= 1'b1;
                    r_out_line   <= echo;
                    r_out_status <= ST_NONE;
                end
                SRC_PING: begin
                    r_out_data   <= PING_WORD[r_idx[1:0]];
                    r_out_host   <= 1'b0;
                    r_out_line   <= 1'b1;
                    r_out_status <= ST_NONE;
                end
                SRC_TERM: begin
                    r_out_data   <= r_term_bytes[{r_idx[1:0], 3'b000} +: 8];
                    r_out_host   <= 1'b0;
                    r_out_line   <= 1'b1;
                    r_out_status <= ST_NONE;
                end
                default: begin
                    r_out_data   <= '0;
                    r_out_host   <= 1'b0;
                    r_out_line   <= 1'b0;
                    r_out_status <= ST_NONE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_to_host   = r_out_host;
    assign o_to_line   = r_out_line;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

[hdl/terminated_frame_receiver.sv]
// terminated frame receiver: one input word in work at a time, one output word register
// plain byte: captured, decoded, then checked for a terminator; timer tick: captured, decoded; results registered
// frame by terminator: byte check, then per frame byte a registered store read and an output step
//   (a status word when empty); tick-ended frames skip the byte check; then ping verdict or echo
// ping request: ping text, then terminator bytes; stalled results hold up all of these
// sync active-low reset restores controller, counters, timer and registers; store not cleared
module terminated_frame_receiver #(
    parameter int FRAME_DEPTH  = tfr_pkg::DEF_FRAME_DEPTH,
    parameter int MAX_TERM_LEN = tfr_pkg::DEF_MAX_TERM_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_to_host,
    output logic        o_to_line,
    output logic [2:0]  o_status,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfr_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // register port never waits
    assign pready = 1'b1;

    // sequencer: takes a word only when idle, then walks the result sequence
    // (overflow, timeout, empty/frame bytes, ping verdict, echoed terminator, ping text and terminator)
    tfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: registers, frame store, terminator compare, timer and output word register
    tfr_dpath #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .MAX_TERM_LEN (MAX_TERM_LEN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_data_byte (o_data_byte),
        .o_to_host   (o_to_host),
        .o_to_line   (o_to_line),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

[hdl/tfr_checker.sv]
`include "terminated_frame_receiver_macros.svh"

module tfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_byte,
    input logic       o_to_host,
    input logic       o_to_line,
    input logic [2:0] o_status,
    input logic       o_last
);

    logic [13:0] out_word;

    assign out_word = {o_data_byte, o_to_host, o_to_line, o_status, o_last};

    // a word in work blocks the next one
    `TFR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall,
        "accepted word did not stall input")

    // more results of the same word still to come, so the sequencer cannot be idle
    `TFR_ASSERT_IMPLY(a_nonlast_busy, o_out_valid && !o_last, o_in_stall,
        "input open before last result")

    // held result word stays put
    `TFR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word),
        "stalled result changed")

endmodule

bind terminated_frame_receiver tfr_checker u_tfr_checker (.*);

[tb/sv/terminated_frame_receiver_test.sv]
module terminated_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfr_pkg::*;

    localparam int FRAME_DEPTH   = DEF_FRAME_DEPTH;
    localparam int MAX_TERM      = DEF_MAX_TERM_LEN;
    // operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_WORDS   = 52;
    // idle cycles after the last result before touching registers or ending
    localparam int SETTLE_CYCLES = 20;
    // long receiver hold-off, long enough for the block to back up its input
    localparam int LONG_HOLD     = 400;
    // tick bursts longer than this are cut short to keep the run bounded
    localparam int MAX_TICK_RUN  = 16;

    // one result word as seen on the output channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       to_host;
        logic       to_line;
        t_status    status;
        logic       last;
    } t_frame_result;

    // one input word waiting to be driven
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } t_rx_word;

    // tracks register values and receiver state, predicts results per accepted word
    class t_frame_tracker;
        logic [2:0]    term_len;
        logic [31:0]   term_bytes;
        logic [15:0]   timeout_ticks;
        logic          echo_on;

        logic [7:0]    frame_mem [FRAME_DEPTH];
        int unsigned   byte_cnt;
        logic [31:0]   tail;
        bit            ping_wait;
        bit            armed;
        int unsigned   ticks_left;

        t_frame_result batch [$];
        t_frame_result due_results [$];

        int errors, checked, words, frames, pongs, bad_pings, timeouts, overflows;

        function new();
            term_len      = 3'd1;
            term_bytes    = 32'd10;
            timeout_ticks = 16'd1000;
            echo_on       = 1'b0;
            byte_cnt      = 0;
            tail          = '0;
            ping_wait     = 0;
            armed         = 0;
            ticks_left    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_TERM_LEN:   term_len      = value[2:0];
                REG_TERM_BYTES: term_bytes    = value;
                REG_TIMEOUT:    timeout_ticks = value[15:0];
                REG_ECHO:       echo_on       = value[0];
                default: ;
            endcase
        endfunction

        // lengths above the maximum saturate
        function int unsigned live_len();
            return (int'(term_len) > MAX_TERM) ? MAX_TERM : int'(term_len);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void queue_result(logic [7:0] d, logic host, logic line, t_status s);
            t_frame_result r;
            r.data_byte = d;
            r.to_host   = host;
            r.to_line   = line;
            r.status    = s;
            r.last      = 1'b0;
            batch.push_back(r);
        endfunction

        function void queue_terminator();
            int unsigned i;
            for (i = 0; i < live_len(); i++)
                queue_result(term_bytes[8*i +: 8], 1'b0, 1'b1, ST_NONE);
        endfunction

        function void arm_timer();
            armed      = 1;
            ticks_left = {16'd0, timeout_ticks};
        endfunction

        function void clear_frame();
            byte_cnt = 0;
            tail     = '0;
            armed    = 0;
        endfunction

        // frame complete: host copy, then echo or ping verdict
        function void deliver_frame();
            int unsigned len, flen, i;
            bit          echo, pong;
            len  = live_len();
            flen = (byte_cnt >= len) ? byte_cnt - len : 0;
            echo = !ping_wait && echo_on;
            if (flen > FRAME_DEPTH)
                flen = FRAME_DEPTH;
            frames++;
            if (flen == 0)
                queue_result(8'h00, 1'b0, 1'b0, ST_EMPTY);
            for (i = 0; i < flen; i++)
                queue_result(frame_mem[i], 1'b1, echo, ST_NONE);
            if (ping_wait) begin
                pong = (flen == PING_LEN);
                if (pong) begin
                    for (i = 0; i < PING_LEN; i++)
                        if (frame_mem[i] != PING_WORD[i])
                            pong = 0;
                end
                ping_wait = 0;
                if (pong) begin
                    pongs++;
                    queue_result(8'h00, 1'b0, 1'b0, ST_PONG);
                end else begin
                    bad_pings++;
                    queue_result(8'h00, 1'b0, 1'b0, ST_BAD_PING);
                end
            end else if (echo) begin
                queue_terminator();
            end
            clear_frame();
        endfunction

        // accepted input word: update state and queue the results it causes
        function void take_word(logic [1:0] op, logic [7:0] b);
            int unsigned   len, i;
            logic [31:0]   got, mask;
            t_frame_result r;
            len = live_len();
            if (op != OP_UNUSED)
                words++;
            case (op)
                OP_BYTE: begin
                    arm_timer();
                    if (byte_cnt >= FRAME_DEPTH) begin
                        byte_cnt = 0;
                        tail     = '0;
                        overflows++;
                        queue_result(8'h00, 1'b0, 1'b0, ST_OVERFLOW);
                    end else begin
                        frame_mem[byte_cnt] = b;
                        byte_cnt++;
                        tail = {b, tail[31:8]};
                        if (len != 0 && byte_cnt >= len) begin
                            mask = (len >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * len)) - 32'd1);
                            got  = tail >> (8 * (4 - len));
                            if (got == (term_bytes & mask))
                                deliver_frame();
                        end
                    end
                end
                OP_TICK: begin
                    // disarmed timer: tick has no effect
                    if (armed) begin
                        if (ticks_left > 1) begin
                            ticks_left--;
                        end else begin
                            ticks_left = 0;
                            armed      = 0;
                            if (len == 0 && byte_cnt > 0) begin
                                deliver_frame();
                            end else begin
                                timeouts++;
                                queue_result(8'h00, 1'b0, 1'b0,
                                             ping_wait ? ST_PING_TOUT : ST_FRAME_TOUT);
                                ping_wait = 0;
                                clear_frame();
                            end
                        end
                    end
                end
                OP_PING: begin
                    ping_wait = 1;
                    arm_timer();
                    for (i = 0; i < PING_LEN; i++)
                        queue_result(PING_WORD[i], 1'b0, 1'b1, ST_NONE);
                    queue_terminator();
                end
                default: ;
            endcase
            // mark the final result of this word
            for (i = 0; i < batch.size(); i++) begin
                r      = batch[i];
                r.last = (i == batch.size() - 1);
                due_results.push_back(r);
            end
            batch.delete();
        endfunction

        function void check_result(t_frame_result seen);
            t_frame_result want;
            checked++;
            if (due_results.size() == 0) begin
                $error("result word with nothing expected: data_byte %0h status %0d",
                       seen.data_byte, seen.status);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (seen.data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, seen.data_byte);
                errors++;
            end
            if (seen.to_host !== want.to_host) begin
                $error("to_host: expected %0b, got %0b", want.to_host, seen.to_host);
                errors++;
            end
            if (seen.to_line !== want.to_line) begin
                $error("to_line: expected %0b, got %0b", want.to_line, seen.to_line);
                errors++;
            end
            if (seen.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, seen.status);
                errors++;
            end
            if (seen.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, seen.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_op;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_data;
    logic        out_host;
    logic        out_line;
    logic [2:0]  out_status;
    logic        out_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_frame_tracker board;
    t_rx_word       stim [$];
    int             planned;
    int             settings;
    bit             hold_request = 1'b0;
    int             stall_pick, stall_len;
    t_frame_result  seen_result;

    terminated_frame_receiver #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .MAX_TERM_LEN (MAX_TERM)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_operation (in_op),
        .i_rx_byte   (in_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_data_byte (out_data),
        .o_to_host   (out_host),
        .o_to_line   (out_line),
        .o_status    (out_status),
        .o_last      (out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result monitor: a word moves when valid is high and we are not stalling
    always @(posedge i_clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            seen_result.data_byte = out_data;
            seen_result.to_host   = out_host;
            seen_result.to_line   = out_line;
            seen_result.status    = t_status'(out_status);
            seen_result.last      = out_last;
            board.check_result(seen_result);
        end
    end

    // receiver stall pattern: short bursts, quiet stretches, rare long stalls,
    // plus one long hold-off on request
    initial begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request <= 1'b0;
                out_stall    <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall_pick = $urandom_range(0, 99);
                if (stall_pick < 50) begin
                    out_stall <= 1'b0;
                    stall_len  = $urandom_range(1, 4);
                end else if (stall_pick < 80) begin
                    out_stall <= 1'b1;
                    stall_len  = $urandom_range(1, 3);
                end else if (stall_pick < 92) begin
                    out_stall <= 1'b0;
                    stall_len  = $urandom_range(20, 60);
                end else if (stall_pick < 98) begin
                    out_stall <= 1'b1;
                    stall_len  = $urandom_range(5, 15);
                end else begin
                    out_stall <= 1'b1;
                    stall_len  = $urandom_range(30, 80);
                end
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // register write: setup cycle, access cycle, then psel dropped; pready is always high
    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [2:0] len, logic [31:0] term, logic [15:0] ticks,
                                logic echo);
        reg_write(REG_TERM_LEN, {29'd0, len});
        reg_write(REG_TERM_BYTES, term);
        reg_write(REG_TIMEOUT, {16'd0, ticks});
        reg_write(REG_ECHO, {31'd0, echo});
        settings++;
    endtask

    // block until every predicted result has been seen, optionally settle after
    task automatic wait_drained(bit settle);
        while (board.outstanding() != 0)
            @(posedge i_clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // offer one word after a random gap, return at the edge that takes it
    task automatic drive_word(t_rx_word w);
        int pick, gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 96)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= w.op;
        in_byte  <= w.rx_byte;
        @(posedge i_clk);
        while (in_stall !== 1'b0)
            @(posedge i_clk);
        board.take_word(w.op, w.rx_byte);
    endtask

    // send the queued words; optional long receiver hold-off and a mid-run pause
    task automatic run_words(bit hold_off, bit pause_mid);
        int i, half;
        half = stim.size() / 2;
        if (hold_off)
            hold_request <= 1'b1;
        for (i = 0; i < stim.size(); i++) begin
            if (pause_mid && i == half) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
                wait_drained(1'b0);
            end
            drive_word(stim[i]);
        end
        in_valid <= 1'b0;
        stim.delete();
    endtask

    task automatic queue_word(logic [1:0] op, logic [7:0] b);
        t_rx_word w;
        w.op      = op;
        w.rx_byte = b;
        stim.push_back(w);
        if (op != OP_UNUSED)
            planned++;
    endtask

    // enough ticks to expire the timer, cut short for very long timeouts
    task automatic queue_ticks(int count);
        int i, n;
        n = (count > MAX_TICK_RUN) ? 3 : ((count < 1) ? 1 : count);
        for (i = 0; i < n; i++)
            queue_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // close a frame: terminator bytes, or a timeout when there is no terminator
    task automatic queue_frame_end();
        int unsigned i;
        if (board.live_len() > 0) begin
            for (i = 0; i < board.live_len(); i++)
                queue_word(OP_BYTE, board.term_bytes[8*i +: 8]);
        end else begin
            queue_ticks(int'(board.timeout_ticks));
        end
    endtask

    // mostly well-formed frames and ping exchanges, some ticks and noise
    task automatic build_random(int target);
        int pick, sub, n, i;
        planned = 0;
        while (planned < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                sub = $urandom_range(0, 99);
                if (sub < 85)
                    n = $urandom_range(0, 6);
                else if (sub < 95)
                    n = $urandom_range(7, 31);
                else
                    n = $urandom_range(FRAME_DEPTH, FRAME_DEPTH + 4);
                for (i = 0; i < n; i++)
                    queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
                queue_frame_end();
            end else if (pick < 60) begin
                queue_word(OP_PING, 8'($urandom_range(0, 255)));
                sub = $urandom_range(0, 99);
                if (sub < 60) begin
                    for (i = 0; i < PING_LEN; i++)
                        queue_word(OP_BYTE, PING_WORD[i]);
                    queue_frame_end();
                end else if (sub < 85) begin
                    n = $urandom_range(0, 5);
                    for (i = 0; i < n; i++)
                        queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
                    queue_frame_end();
                end else begin
                    queue_ticks(int'(board.timeout_ticks));
                end
            end else if (pick < 72) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    queue_word(OP_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
                // partial frame left to time out
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
                queue_ticks(int'(board.timeout_ticks));
            end else if (pick < 95) begin
                queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        board    = new();
        settings = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_op    = OP_BYTE;
        in_byte  = 8'h00;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: cr-lf terminator, echo on, two-tick timeout
        apply_config(3'd2, 32'h0000_0A0D, 16'd2, 1'b1);
        queue_word(OP_BYTE, 8'h00);
        queue_word(OP_BYTE, 8'hFF);
        queue_word(OP_BYTE, 8'h0D);
        queue_word(OP_BYTE, 8'h0A);
        // terminator alone gives an empty frame, still echoed
        queue_word(OP_BYTE, 8'h0D);
        queue_word(OP_BYTE, 8'h0A);
        // ping answered by a correct reply
        queue_word(OP_PING, 8'h00);
        queue_word(OP_BYTE, PING_WORD[0]);
        queue_word(OP_BYTE, PING_WORD[1]);
        queue_word(OP_BYTE, PING_WORD[2]);
        queue_word(OP_BYTE, PING_WORD[3]);
        queue_word(OP_BYTE, 8'h0D);
        queue_word(OP_BYTE, 8'h0A);
        // ping answered by garbage
        queue_word(OP_PING, 8'hFF);
        queue_word(OP_BYTE, 8'h58);
        queue_word(OP_BYTE, 8'h0D);
        queue_word(OP_BYTE, 8'h0A);
        // ping with no reply times out
        queue_word(OP_PING, 8'h00);
        queue_word(OP_TICK, 8'h00);
        queue_word(OP_TICK, 8'hFF);
        // frame with no terminator times out
        queue_word(OP_BYTE, 8'h55);
        queue_word(OP_TICK, 8'h00);
        queue_word(OP_TICK, 8'h00);
        // tick while the timer is disarmed, then the unused operation
        queue_word(OP_TICK, 8'h00);
        queue_word(OP_UNUSED, 8'hAA);
        run_words(1'b0, 1'b0);
        wait_drained(1'b1);

        // single-byte terminator, short timeout; receiver holds off for a long stretch
        apply_config(3'd1, 32'h0000_000A, 16'd4, 1'b0);
        build_random(PHASE_WORDS);
        run_words(1'b1, 1'b0);
        wait_drained(1'b1);

        // all-ones four-byte terminator, longest timeout; sender pauses halfway
        apply_config(3'd4, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        build_random(PHASE_WORDS);
        run_words(1'b0, 1'b1);
        wait_drained(1'b1);

        // no terminator: frames end only by timeout
        apply_config(3'd0, 32'h0000_0000, 16'd1, 1'b1);
        build_random(PHASE_WORDS);
        run_words(1'b0, 1'b0);
        wait_drained(1'b1);

        // oversized length saturates, zero timeout fires on the first tick
        apply_config(3'd7, 32'h0A0D_0A0D, 16'd0, 1'b0);
        build_random(PHASE_WORDS);
        run_words(1'b0, 1'b0);
        wait_drained(1'b1);

        // random three-byte terminator
        apply_config(3'd3, $urandom(), 16'd3, 1'b1);
        build_random(PHASE_WORDS);
        run_words(1'b0, 1'b0);
        wait_drained(1'b1);

        // random two-byte terminator, timeout and echo
        apply_config(3'd2, $urandom(), 16'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
        build_random(PHASE_WORDS);
        run_words(1'b0, 1'b0);
        wait_drained(1'b1);

        $display("covered %0d input words under %0d register settings, %0d results checked",
                 board.words, settings, board.checked);
        $display("frames %0d, pongs %0d, bad ping replies %0d, timeouts %0d, overflows %0d",
                 board.frames, board.pongs, board.bad_pings, board.timeouts, board.overflows);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
